// ===== src/imu_angle_frame_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// imu angle frame parser assertion macros
// concurrent assertion wrappers clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef IMU_ANGLE_FRAME_PARSER_UNIT_MACROS_SVH
`define IMU_ANGLE_FRAME_PARSER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IAFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IAFP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IAFP_ASSERT(name, prop, msg)
`define IAFP_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ===== src/iafp_pkg.sv =====
// ----------------------------------------------------------------------------
// iafp_pkg
// shared types and constants of the imu angle frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package iafp_pkg;

  localparam int FRAME_LEN = 11;
  localparam int WIN_LEN   = FRAME_LEN - 1;
  localparam int FILL_W    = $clog2(FRAME_LEN);
  localparam int YAW_W     = 16;
  localparam int FILT_W    = 24;
  localparam int WGT_W     = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef logic [7:0]                rx_byte_t;
  typedef logic signed [YAW_W-1:0]   yaw_t;
  typedef logic signed [FILT_W-1:0]  filt_t;
  typedef logic [WGT_W-1:0]          wgt_t;

  localparam rx_byte_t SYNC_BYTE       = 8'h55;
  localparam rx_byte_t FRAME_TYPE_RST  = 8'h53;
  localparam wgt_t     NEW_WEIGHT_RST  = 9'd230;
  localparam wgt_t     WEIGHT_FULL     = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TYPE = 1'b0,
    CFG_NEW_WEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== src/imu_angle_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_unit
// serial imu 11-byte angle frame parser with fixed-point yaw low-pass filter
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while in_full is low, set by the combinational
//   window check and the filter multiply-add
// result path: the byte that completes a valid frame passes the yaw queue,
//   then the result register, before it shows on the out_ ports
// reset: synchronous rst_n clears window fill, yaw queue, filter state,
//   toggle flag and loads frame_type 0x53 and new_weight 230
`default_nettype none

`include "imu_angle_frame_parser_unit_macros.svh"

module imu_angle_frame_parser_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_push,
  output logic                             in_full,
  input  iafp_pkg::rx_byte_t               in_rx_byte,
  output logic                             out_empty,
  input  wire                              out_pop,
  output iafp_pkg::filt_t                  out_filtered_yaw,
  output iafp_pkg::yaw_t                   out_raw_yaw,
  output logic                             out_frame_toggle,
  input  wire                              cfg_wr_en,
  input  wire [iafp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [iafp_pkg::CFG_W-1:0]        cfg_wdata
);
  import iafp_pkg::*;

  rx_byte_t  frame_type_r;
  wgt_t      new_weight_r;
  logic      byte_vld;
  logic      q_push;
  yaw_t      q_wdata;
  yaw_t      q_rdata;
  logic      q_pop;
  q_stat_t   q_stat;
  logic      res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_type_r <= FRAME_TYPE_RST;
      new_weight_r <= NEW_WEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_TYPE: frame_type_r <= cfg_wdata[7:0];
        CFG_NEW_WEIGHT: new_weight_r <= cfg_wdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_full  = q_stat.full;
  assign byte_vld = in_push && !in_full;

  iafp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld   (byte_vld),
    .rx_byte    (in_rx_byte),
    .frame_type (frame_type_r),
    .yaw_vld    (q_push),
    .yaw        (q_wdata)
  );

  iafp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back side takes a sample when the result register is free or drains
  assign q_pop     = !q_stat.empty && (!res_vld || out_pop);
  assign out_empty = !res_vld;

  iafp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (q_pop),
    .yaw          (q_rdata),
    .new_weight   (new_weight_r),
    .res_pop      (out_pop),
    .res_vld      (res_vld),
    .filtered_yaw (out_filtered_yaw),
    .raw_yaw      (out_raw_yaw),
    .frame_toggle (out_frame_toggle)
  );

  `IAFP_ASSERT_NEVER(a_q_overflow, q_push && q_stat.full, "yaw queue overflow")
  `IAFP_ASSERT_NEVER(a_q_underflow, q_pop && q_stat.empty, "yaw queue underflow")
  `IAFP_ASSERT(a_res_after_take, q_pop |=> !out_empty, "result missing after queue pop")
  `IAFP_ASSERT(a_toggle_flips, q_pop |=> (out_frame_toggle != $past(out_frame_toggle)), "toggle did not flip")

endmodule

`default_nettype wire

// ===== src/iafp_front.sv =====
// ----------------------------------------------------------------------------
// iafp_front
// byte window, sync/type/checksum check and yaw extraction
// ----------------------------------------------------------------------------
`default_nettype none

module iafp_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 byte_vld,
  input  iafp_pkg::rx_byte_t  rx_byte,
  input  iafp_pkg::rx_byte_t  frame_type,
  output logic                yaw_vld,
  output iafp_pkg::yaw_t      yaw
);
  import iafp_pkg::*;

  rx_byte_t              win_r [WIN_LEN];
  logic [FILL_W-1:0]     fill_r;
  logic [FILL_W-1:0]     fill_nxt;
  rx_byte_t              sum;
  logic                  win_full;
  logic                  frame_ok;

  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      sum = sum + win_r[i];
    end
  end

  assign win_full = (fill_r == FILL_W'(WIN_LEN));
  assign frame_ok = win_full && (win_r[0] == SYNC_BYTE) && (win_r[1] == frame_type)
                    && (sum == rx_byte);
  assign yaw_vld  = byte_vld && frame_ok;
  assign yaw      = {win_r[7], win_r[6]};

  always_comb begin
    fill_nxt = fill_r;
    if (byte_vld) begin
      if (!win_full) begin
        fill_nxt = fill_r + FILL_W'(1);
      end else if (frame_ok) begin
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // window payload, entries past the fill count do not affect frame_ok
  always_ff @(posedge clk) begin
    if (byte_vld) begin
      if (!win_full) begin
        win_r[fill_r] <= rx_byte;
      end else if (!frame_ok) begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WIN_LEN-1] <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/iafp_fifo.sv =====
// ----------------------------------------------------------------------------
// iafp_fifo
// short queue of yaw samples between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module iafp_fifo (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  iafp_pkg::yaw_t     wdata,
  input  wire                pop,
  output iafp_pkg::yaw_t     rdata,
  output iafp_pkg::q_stat_t  stat
);
  import iafp_pkg::*;

  yaw_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  cnt_r;
  logic [Q_CNT_W-1:0]  cnt_nxt;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + Q_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - Q_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/iafp_back.sv =====
// ----------------------------------------------------------------------------
// iafp_back
// yaw low-pass filter update, toggle flag and result register
// ----------------------------------------------------------------------------
`default_nettype none

module iafp_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                take,
  input  iafp_pkg::yaw_t     yaw,
  input  iafp_pkg::wgt_t     new_weight,
  input  wire                res_pop,
  output logic               res_vld,
  output iafp_pkg::filt_t    filtered_yaw,
  output iafp_pkg::yaw_t     raw_yaw,
  output logic               frame_toggle
);
  import iafp_pkg::*;

  localparam int DIFF_W = FILT_W + 1;
  localparam int PROD_W = DIFF_W + WGT_W + 1;

  filt_t                     filt_r;
  filt_t                     filt_nxt;
  yaw_t                      raw_r;
  logic                      tog_r;
  logic                      vld_r;
  logic                      vld_nxt;
  wgt_t                      w_sat;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;

  // old + floor(w * (sample*256 - old) / 256)
  assign w_sat    = new_weight[WGT_W-1] ? WEIGHT_FULL : new_weight;
  assign diff     = DIFF_W'(signed'({yaw, 8'h00})) - DIFF_W'(filt_r);
  assign prod     = PROD_W'(diff) * PROD_W'(signed'({1'b0, w_sat}));
  assign filt_nxt = filt_r + prod[FILT_W+7:8];

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (res_pop) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      filt_r <= '0;
      tog_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (take) begin
        filt_r <= filt_nxt;
        tog_r  <= ~tog_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      raw_r <= yaw;
    end
  end

  assign res_vld      = vld_r;
  assign filtered_yaw = filt_r;
  assign raw_yaw      = raw_r;
  assign frame_toggle = tog_r;

endmodule

`default_nettype wire
